// ===== rtl/background_subtraction_motion_mask_unit_defines.svh =====
// Assertion macros used by the motion mask checker
`ifndef BACKGROUND_SUBTRACTION_MOTION_MASK_UNIT_DEFINES_SVH
`define BACKGROUND_SUBTRACTION_MOTION_MASK_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, held off during reset
`define BSMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motion mask check failed");

// next-cycle implication, sampled on clk, held off during reset
`define BSMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motion mask check failed");

`endif

// ===== rtl/bsmm_pkg.sv =====
// Package: widths, register codes and payload types of the motion mask unit
`timescale 1ns / 1ps
package bsmm_pkg;

  localparam int FRAME_PIXELS = 65536;
  localparam int POS_W        = $clog2(FRAME_PIXELS);

  localparam int LUMA_W   = 8;
  localparam int MASK_W   = 8;
  localparam int WEIGHT_W = 13;
  localparam int THR_W    = 8;
  localparam int BG_W     = 32;
  localparam int FRAC_W   = 12;
  localparam int BG_HI_W  = BG_W - FRAC_W;
  localparam int PNEW_W   = BG_W - FRAC_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WEIGHT_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 3);

  localparam logic [MASK_W-1:0] MASK_FG = 8'd255;
  localparam logic [MASK_W-1:0] MASK_BG = 8'd0;

  localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST = 13'd205;
  localparam logic [WEIGHT_W-1:0] OLD_WEIGHT_RST = 13'd3891;
  localparam logic [THR_W-1:0]    THRESHOLD_RST  = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEW_WEIGHT     = 2'd0,
    CFG_OLD_WEIGHT     = 2'd1,
    CFG_DIFF_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask_value;
    logic              frame_end_out;
  } result_t;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

// ===== rtl/bsmm_channels.sv =====
// Interfaces: pixel request, mask result and configuration write channels
`timescale 1ns / 1ps
interface bsmm_in_if;
  import bsmm_pkg::*;
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] luma;
  logic              frame_end;
  modport source (output valid, output luma, output frame_end, input ready);
  modport sink (input valid, input luma, input frame_end, output ready);
endinterface

interface bsmm_out_if;
  import bsmm_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] mask_value;
  logic              frame_end_out;
  modport source (output valid, output mask_value, output frame_end_out, input ready);
  modport sink (input valid, input mask_value, input frame_end_out, output ready);
endinterface

interface bsmm_cfg_if;
  import bsmm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/background_subtraction_motion_mask_unit.sv =====
// Top level: running-average background subtraction with a per-pixel motion mask
//
//  channel  | dir | payload                        | handshake
//  ---------+-----+--------------------------------+-------------
//  in_req   | in  | luma[7:0], frame_end           | valid/ready
//  out_rsp  | out | mask_value[7:0], frame_end_out | valid/ready
//  cfg_req  | in  | reg_index[1:0], wr_data[12:0]  | valid/ready
//
//  One pixel per cycle sustained while in_req.ready stays high.
//  A result passes the background RAM read, the stage 2 registers and the result queue, in that order.
//  Reset is synchronous, active low; the background RAM is not cleared, the first frame fills it.
//  A stalled output fills a four-entry result queue; in_req.ready drops when it would overflow.
//  cfg_req.ready is always high.
`timescale 1ns / 1ps
module background_subtraction_motion_mask_unit (
  input logic        clk,
  input logic        rst_n,
  bsmm_in_if.sink    in_req,
  bsmm_out_if.source out_rsp,
  bsmm_cfg_if.sink   cfg_req
);
  import bsmm_pkg::*;

  logic                in_acc;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                warm_r, warm_nxt;
  logic [WEIGHT_W-1:0] new_weight_r, old_weight_r;
  logic [THR_W-1:0]    threshold_r;

  logic                s1_v_r;
  logic [LUMA_W-1:0]   s1_luma_r;
  logic                s1_last_r;
  logic [POS_W-1:0]    s1_addr_r;
  logic                s1_warm_r;

  logic                s2_v_r;
  logic [MASK_W-1:0]   s2_mask_r;
  logic                s2_last_r;
  logic [POS_W-1:0]    s2_addr_r;
  logic [PNEW_W-1:0]   s2_pnew_r;
  logic [BG_W-1:0]     s2_pold_r;

  logic                wb_v_r;
  logic [POS_W-1:0]    wb_addr_r;
  logic [BG_W-1:0]     wb_data_r;

  logic [BG_W-1:0]     ram_rdata;
  logic [BG_W-1:0]     s1_bg;
  logic [LUMA_W-1:0]   s1_diff;
  logic [MASK_W-1:0]   s1_mask;
  logic [PNEW_W:0]     s1_pnew;
  logic [BG_W:0]       s1_pold;
  logic [BG_W-1:0]     s2_sum;

  result_t             push_data;
  result_t             head;
  logic                head_valid;
  fifo_stat_t          fifo_stat;
  logic [FIFO_CNT_W-1:0] in_flight;

  // configuration
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_weight_r <= NEW_WEIGHT_RST;
      old_weight_r <= OLD_WEIGHT_RST;
      threshold_r  <= THRESHOLD_RST;
    end else if (cfg_req.valid) begin
      case (cfg_idx_t'(cfg_req.reg_index))
        CFG_NEW_WEIGHT:     new_weight_r <= cfg_req.wr_data;
        CFG_OLD_WEIGHT:     old_weight_r <= cfg_req.wr_data;
        CFG_DIFF_THRESHOLD: threshold_r  <= cfg_req.wr_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // request side: hold requests back while the queue could not take every result in flight
  assign in_flight    = fifo_stat.count + FIFO_CNT_W'(s1_v_r) + FIFO_CNT_W'(s2_v_r);
  assign in_req.ready = (in_flight < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_acc       = in_req.valid && in_req.ready;

  always_comb begin
    pos_nxt  = pos_r;
    warm_nxt = warm_r;
    if (in_acc) begin
      if (in_req.frame_end || (pos_r == POS_W'(FRAME_PIXELS - 1))) begin
        pos_nxt  = '0;
        warm_nxt = 1'b1;
      end else begin
        pos_nxt  = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      warm_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      warm_r <= warm_nxt;
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        wb_v_r <= 1'b1;
      end
    end
  end

  bsmm_ram #(
    .WIDTH (BG_W),
    .DEPTH (FRAME_PIXELS)
  ) u_bg_ram (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_addr_r),
    .wdata (s2_sum),
    .re    (in_acc),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // stage 1: background select with forwarding, compare, multiply
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_luma_r <= in_req.luma;
      s1_last_r <= in_req.frame_end;
      s1_addr_r <= pos_r;
      s1_warm_r <= warm_r;
    end
  end

  always_comb begin
    if (!s1_warm_r) begin
      s1_bg = {s1_luma_r, {(BG_W - LUMA_W){1'b0}}};
    end else if (s2_v_r && (s2_addr_r == s1_addr_r)) begin
      s1_bg = s2_sum;
    end else if (wb_v_r && (wb_addr_r == s1_addr_r)) begin
      s1_bg = wb_data_r;
    end else begin
      s1_bg = ram_rdata;
    end
    s1_diff = (s1_bg[BG_W-1 -: LUMA_W] > s1_luma_r) ? s1_bg[BG_W-1 -: LUMA_W] - s1_luma_r
                                                     : s1_luma_r - s1_bg[BG_W-1 -: LUMA_W];
    s1_mask = (s1_diff > threshold_r) ? MASK_FG : MASK_BG;
    s1_pnew = (PNEW_W + 1)'(new_weight_r) * (PNEW_W + 1)'(s1_luma_r);
    s1_pold = (BG_W + 1)'(old_weight_r) * (BG_W + 1)'(s1_bg[BG_W-1 -: BG_HI_W]);
  end

  // stage 2: sum, write back, queue result
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_mask_r <= s1_mask;
      s2_last_r <= s1_last_r;
      s2_addr_r <= s1_addr_r;
      s2_pnew_r <= s1_pnew[PNEW_W-1:0];
      s2_pold_r <= s1_pold[BG_W-1:0];
    end
    if (s2_v_r) begin
      wb_addr_r <= s2_addr_r;
      wb_data_r <= s2_sum;
    end
  end

  assign s2_sum = {s2_pnew_r, {FRAC_W{1'b0}}} + s2_pold_r;

  assign push_data.mask_value    = s2_mask_r;
  assign push_data.frame_end_out = s2_last_r;

  bsmm_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s2_v_r),
    .push_data  (push_data),
    .pop        (head_valid && out_rsp.ready),
    .head       (head),
    .head_valid (head_valid),
    .stat       (fifo_stat)
  );

  assign out_rsp.valid         = head_valid;
  assign out_rsp.mask_value    = head.mask_value;
  assign out_rsp.frame_end_out = head.frame_end_out;

endmodule

// ===== rtl/bsmm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
module bsmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bsmm_out_fifo.sv =====
// Result queue that decouples the update pipeline from the output handshake
`timescale 1ns / 1ps
module bsmm_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bsmm_pkg::result_t   push_data,
  input  logic                pop,
  output bsmm_pkg::result_t   head,
  output logic                head_valid,
  output bsmm_pkg::fifo_stat_t stat
);
  import bsmm_pkg::*;

  result_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign stat.push  = push;
  assign stat.pop   = pop;
  assign stat.count = count_r;

endmodule

// ===== rtl/bsmm_checker.sv =====
// Port-level checker for the motion mask unit, bound to the top level
`timescale 1ns / 1ps
`include "background_subtraction_motion_mask_unit_defines.svh"
module bsmm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bsmm_pkg::MASK_W-1:0] out_mask
);
  import bsmm_pkg::*;

  logic [FIFO_CNT_W-1:0] pending_r, pending_nxt;
  logic                  in_hs, out_hs;

  assign in_hs       = in_valid && in_ready;
  assign out_hs      = out_valid && out_ready;
  assign pending_nxt = pending_r + FIFO_CNT_W'(in_hs) - FIFO_CNT_W'(out_hs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `BSMM_ASSERT_NOW(a_no_spurious_result, out_valid, pending_r != '0)
  `BSMM_ASSERT_NOW(a_pending_bounded, 1'b1, pending_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `BSMM_ASSERT_NOW(a_mask_levels, out_valid, (out_mask == MASK_FG) || (out_mask == MASK_BG))
  `BSMM_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

endmodule

bind background_subtraction_motion_mask_unit bsmm_checker u_bsmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_mask  (out_rsp.mask_value)
);
